// ----- rtl/wwh_pkg.sv -----
// ============================================================================
// wwh_pkg
// Shared types, constants and helpers for the wide word hash engine.
// ============================================================================
package wwh_pkg;

    localparam int WORD_W         = 64;
    localparam int IDX_W          = 4;
    localparam int CHUNK_WORDS    = 16;
    localparam int ROUNDS_DEFAULT = 12;

    // Initial chaining value.
    localparam logic [WORD_W-1:0] IV_0 = 64'hF3BC_C908_6A64_3376;
    localparam logic [WORD_W-1:0] IV_1 = 64'h6745_2301_1EFC_DB2F;
    localparam logic [WORD_W-1:0] IV_2 = 64'h98BA_DCFE_1032_5476;
    localparam logic [WORD_W-1:0] IV_3 = 64'hC3D2_E1F0_0000_0000;

    // Word 0 of the padding chunk; all other padding words are zero.
    localparam logic [WORD_W-1:0] PAD_WORD = 64'h80;

    // Last index of a chunk.
    localparam logic [IDX_W-1:0] LAST_IDX = 4'hF;

    // Request codes.
    localparam logic REQ_DATA   = 1'b0;
    localparam logic REQ_FINISH = 1'b1;

    // Rotate amounts of the four quarter steps.
    localparam int ROT_P = 7;
    localparam int ROT_T = 9;
    localparam int ROT_S = 13;
    localparam int ROT_Q = 18;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_FOLD
    } t_state;

    // One round takes five steps: four chained quarter steps and a mix.
    typedef enum logic [2:0] {
        STEP_P,
        STEP_T,
        STEP_S,
        STEP_Q,
        STEP_MIX
    } t_step;

    typedef struct packed {
        logic             wr_en;
        logic [IDX_W-1:0] wr_idx;
        logic             start;
        logic             pad;
        logic             step_en;
        t_step            step;
        logic [1:0]       quarter;
        logic             fold;
        logic             emit;
    } t_cmd;

    typedef struct packed {
        logic out_busy;
    } t_status;

    function automatic logic [WORD_W-1:0] rotr(input logic [WORD_W-1:0] x, input int n);
        return (x >> n) | (x << (WORD_W - n));
    endfunction

endpackage

// ----- rtl/wwh_ctrl.sv -----
// ============================================================================
// wwh_ctrl
// Sequencer: counts buffered words, starts compressions, steps through the
// rounds and schedules the final fold and digest hand-off.
// ============================================================================
module wwh_ctrl #(
    parameter int ROUNDS = wwh_pkg::ROUNDS_DEFAULT
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic             i_req_type,
    input  wwh_pkg::t_status i_status,
    output wwh_pkg::t_cmd    o_cmd
);
    import wwh_pkg::*;

    localparam int RW = ($clog2(ROUNDS) > 2) ? $clog2(ROUNDS) : 2;
    localparam logic [RW-1:0] LAST_ROUND = RW'(ROUNDS - 1);

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_words, n_words;
    logic [RW-1:0]    r_round, n_round;
    t_step            r_step, n_step;
    logic             r_pad, n_pad;

    logic w_accept;
    logic w_start;
    logic w_fold_ok;

    assign w_accept  = (r_state == S_IDLE) && i_in_valid;
    assign w_start   = w_accept && ((i_req_type == REQ_FINISH) || (r_words == LAST_IDX));
    assign w_fold_ok = !(r_pad && i_status.out_busy);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_start) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (r_step == STEP_MIX && r_round == LAST_ROUND) begin
                    n_state = S_FOLD;
                end
            end
            S_FOLD: begin
                if (w_fold_ok) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.step = r_step;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (w_accept && i_req_type == REQ_DATA) begin
                    o_cmd.wr_en  = 1'b1;
                    o_cmd.wr_idx = r_words;
                end
                o_cmd.start = w_start;
                o_cmd.pad   = (i_req_type == REQ_FINISH);
            end
            S_RUN: begin
                o_cmd.step_en = 1'b1;
                o_cmd.quarter = r_round[1:0];
            end
            S_FOLD: begin
                o_cmd.fold = w_fold_ok;
                o_cmd.emit = w_fold_ok && r_pad;
            end
            default: o_cmd = '0;
        endcase
    end

    // Counters.
    always_comb begin
        n_words = r_words;
        n_round = r_round;
        n_step  = r_step;
        n_pad   = r_pad;
        if (w_accept) begin
            n_words = (i_req_type == REQ_FINISH) ? '0 : r_words + 1'b1;
        end
        if (w_start) begin
            n_round = '0;
            n_step  = STEP_P;
            n_pad   = (i_req_type == REQ_FINISH);
        end else if (r_state == S_RUN) begin
            if (r_step == STEP_MIX) begin
                n_step  = STEP_P;
                n_round = r_round + 1'b1;
            end else begin
                n_step = t_step'(r_step + 3'd1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_words <= '0;
            r_round <= '0;
            r_step  <= STEP_P;
            r_pad   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_words <= n_words;
            r_round <= n_round;
            r_step  <= n_step;
            r_pad   <= n_pad;
        end
    end

    a_round_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_RUN |-> r_round <= LAST_ROUND)
        else $error("round counter ran past the last round");

    a_finish_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && i_req_type == REQ_FINISH |=> r_words == '0 && r_state == S_RUN)
        else $error("finish did not drop the partial chunk and start padding");

    a_full_chunk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && i_req_type == REQ_DATA && r_words == LAST_IDX |=>
            r_words == '0 && r_state == S_RUN && !r_pad)
        else $error("full chunk did not start a compression");

endmodule

// ----- rtl/wwh_dp.sv -----
// ============================================================================
// wwh_dp
// Datapath: chunk buffer, chaining value, working words, the shared
// rotate-xor-add unit and the digest output register.
// ============================================================================
module wwh_dp (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  wwh_pkg::t_cmd              i_cmd,
    input  logic [wwh_pkg::WORD_W-1:0] i_data_word,
    input  logic                       i_out_ready,
    output wwh_pkg::t_status           o_status,
    output logic                       o_out_valid,
    output logic [wwh_pkg::WORD_W-1:0] o_digest_0,
    output logic [wwh_pkg::WORD_W-1:0] o_digest_1,
    output logic [wwh_pkg::WORD_W-1:0] o_digest_2,
    output logic [wwh_pkg::WORD_W-1:0] o_digest_3
);
    import wwh_pkg::*;

    logic [WORD_W-1:0] r_buf [CHUNK_WORDS];
    logic [WORD_W-1:0] r_chain [4];
    logic [WORD_W-1:0] r_h [4];
    logic [WORD_W-1:0] r_p, r_t, r_s, r_q;
    logic [WORD_W-1:0] r_dig [4];
    logic              r_pad_mode;
    logic              r_out_valid;

    logic [1:0]        w_k;
    logic [IDX_W-1:0]  w_idx;
    logic [WORD_W-1:0] w_msg;
    logic [WORD_W-1:0] w_addend;
    logic [WORD_W-1:0] w_rot;
    logic [WORD_W-1:0] w_sum;

    // Message word index of each quarter step within the current round.
    always_comb begin
        case (i_cmd.step)
            STEP_P:  w_k = 2'd2;
            STEP_T:  w_k = 2'd3;
            STEP_S:  w_k = 2'd0;
            STEP_Q:  w_k = 2'd1;
            default: w_k = 2'd0;
        endcase
    end

    assign w_idx = {i_cmd.quarter, w_k};
    assign w_msg = r_pad_mode ? ((w_idx == '0) ? PAD_WORD : '0) : r_buf[w_idx];

    // Shared rotate-xor-add unit of the right-rotating lane.
    always_comb begin
        case (i_cmd.step)
            STEP_P: begin
                w_addend = r_h[0];
                w_rot    = rotr(r_h[1] ^ r_h[2] ^ r_h[3] ^ w_msg, ROT_P);
            end
            STEP_T: begin
                w_addend = r_h[3];
                w_rot    = rotr(r_p ^ r_h[1] ^ r_h[2] ^ w_msg, ROT_T);
            end
            STEP_S: begin
                w_addend = r_h[2];
                w_rot    = rotr(r_t ^ r_p ^ r_h[1] ^ w_msg, ROT_S);
            end
            STEP_Q: begin
                w_addend = r_h[1];
                w_rot    = rotr(r_s ^ r_t ^ r_p ^ w_msg, ROT_Q);
            end
            default: begin
                w_addend = '0;
                w_rot    = '0;
            end
        endcase
    end

    assign w_sum = w_addend + w_rot;

    // Chunk buffer.
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_buf[i_cmd.wr_idx] <= i_data_word;
        end
    end

    // Working words.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_h        <= r_chain;
            r_pad_mode <= i_cmd.pad;
        end else if (i_cmd.step_en) begin
            case (i_cmd.step)
                STEP_P: r_p <= w_sum;
                STEP_T: r_t <= w_sum;
                STEP_S: r_s <= w_sum;
                STEP_Q: r_q <= w_sum;
                STEP_MIX: begin
                    r_h[0] <= r_h[1] + r_p;
                    r_h[1] <= r_h[2] + r_q;
                    r_h[2] <= r_h[3] + r_s;
                    r_h[3] <= r_h[0] + r_t;
                end
                default: r_p <= r_p;
            endcase
        end
    end

    // Chaining value and digest register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chain[0] <= IV_0;
            r_chain[1] <= IV_1;
            r_chain[2] <= IV_2;
            r_chain[3] <= IV_3;
        end else if (i_cmd.fold) begin
            if (i_cmd.emit) begin
                r_chain[0] <= IV_0;
                r_chain[1] <= IV_1;
                r_chain[2] <= IV_2;
                r_chain[3] <= IV_3;
            end else begin
                for (int i = 0; i < 4; i++) begin
                    r_chain[i] <= r_chain[i] ^ r_h[i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            for (int i = 0; i < 4; i++) begin
                r_dig[i] <= r_chain[i] ^ r_h[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_status.out_busy = r_out_valid && !i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_digest_0        = r_dig[0];
    assign o_digest_1        = r_dig[1];
    assign o_digest_2        = r_dig[2];
    assign o_digest_3        = r_dig[3];

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> !(r_out_valid && !i_out_ready))
        else $error("digest overwritten while the previous one was stalled");

    a_iv_reload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |=> r_out_valid && r_chain[0] == IV_0 && r_chain[3] == IV_3)
        else $error("digest emit did not reload the IV");

    a_emit_on_fold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> i_cmd.fold && r_pad_mode)
        else $error("digest emitted outside a padding fold");

endmodule

// ----- rtl/wide_word_hash_engine.sv -----
// ============================================================================
// wide_word_hash_engine
// Hashes a stream of 64-bit little-endian words into a 256-bit digest.
// ============================================================================
// Usage:
//   The input channel (i_in_valid / o_in_ready) carries one beat per item.
//   A beat with i_req_type = data stores i_data_word in the chunk buffer; the
//   sixteenth data beat of a chunk starts a compression. A beat with
//   i_req_type = finish drops any partial chunk, compresses the padding
//   chunk and then presents the digest on the output channel
//   (o_out_valid / i_out_ready) as four 64-bit words.
// Timing:
//   A data beat that does not close a chunk leaves o_in_ready high. A
//   compression uses one shared rotate-xor-add adder, one quarter step per
//   cycle, plus a mix step per round, and then a fold step; o_in_ready is
//   low during that time. After a finish beat the digest is loaded into the
//   output register at the fold step of the padding compression.
// Stalls:
//   The digest sits in an output register, so data beats for the next
//   message are taken while it waits. A second finish holds in its fold
//   step until the previous digest has been taken.
// Reset:
//   Synchronous, active low. The chaining value returns to the IV, the word
//   count to zero and both channels go idle. No clearing pass is needed.
// ============================================================================
module wide_word_hash_engine #(
    parameter int ROUNDS = wwh_pkg::ROUNDS_DEFAULT
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic                       i_req_type,
    input  logic [wwh_pkg::WORD_W-1:0] i_data_word,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [wwh_pkg::WORD_W-1:0] o_digest_0,
    output logic [wwh_pkg::WORD_W-1:0] o_digest_1,
    output logic [wwh_pkg::WORD_W-1:0] o_digest_2,
    output logic [wwh_pkg::WORD_W-1:0] o_digest_3
);
    import wwh_pkg::*;

    // Commands flow from the sequencer to the datapath; the only status
    // returned is whether the digest register holds a digest not yet taken.
    t_cmd    w_cmd;
    t_status w_status;

    wwh_ctrl #(
        .ROUNDS (ROUNDS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_req_type (i_req_type),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    wwh_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_data_word (i_data_word),
        .i_out_ready (i_out_ready),
        .o_status    (w_status),
        .o_out_valid (o_out_valid),
        .o_digest_0  (o_digest_0),
        .o_digest_1  (o_digest_1),
        .o_digest_2  (o_digest_2),
        .o_digest_3  (o_digest_3)
    );

endmodule
